// ===== hw/rtl/assert_macros.svh =====
// shared assertion macros for the stack rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define MMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define MMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/mms_pkg.sv =====
package mms_pkg;

  // fixed field widths of the result transaction
  localparam int OUT_VALUE_W = 32;
  localparam int FILL_W      = 8;
  localparam int FAULT_W     = 2;

  // operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_FULL  = 2'd1,
    FAULT_EMPTY = 2'd2
  } fault_t;

  typedef enum logic {
    ST_IDLE,
    ST_RELOAD
  } state_t;

endpackage

// ===== hw/rtl/mms_ram.sv =====
module mms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // registered read, holds when not enabled
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/min_max_stack_top.sv =====
// min/max stack: a lifo of signed values that also reports its running
// minimum and maximum, kept in two auxiliary stacks in block ram.
// input channel: in_valid/in_stall with in_mode (0 push, 1 pop) and in_value.
// result channel: out_valid/out_stall, one result transaction per input
// transaction, in order.
// a push, or any faulting transaction, has its result in the output
// register in the cycle after acceptance; a pop that removes a value first
// goes through the reload state, since the new top entries come back from
// the rams as registered reads.
// throughput: one push per cycle while the receiver does not stall; a
// successful pop stalls the input while the tops reload, until its result is written.
// the tops of all three stacks are cached in registers, the rams hold every entry.
// reset clears the three counts, so the stack comes up empty at once with
// no clearing pass; ram data read from an unwritten entry never reaches a result.
// when the receiver stalls, the result register holds and the input stalls
// until the result is taken or is being taken in the same cycle.
`include "assert_macros.svh"

module min_max_stack_top #(
  parameter int STACK_DEPTH = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_mode,
  input  logic signed [31:0]                     in_value,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mms_pkg::OUT_VALUE_W-1:0] out_popped_value,
  output logic                                   out_popped_was_min,
  output logic                                   out_popped_was_max,
  output logic signed [mms_pkg::OUT_VALUE_W-1:0] out_current_min,
  output logic signed [mms_pkg::OUT_VALUE_W-1:0] out_current_max,
  output logic [mms_pkg::FILL_W-1:0]             out_fill_level,
  output logic                                   out_is_empty,
  output logic [mms_pkg::FAULT_W-1:0]            out_fault
);
  import mms_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] vc_r, vc_nxt;   // value stack count
  logic [CW-1:0] mc_r, mc_nxt;   // min stack count
  logic [CW-1:0] xc_r, xc_nxt;   // max stack count
  logic          out_valid_r, out_valid_nxt;

  // cached top entries
  logic [VW-1:0] val_top_r, val_top_nxt;
  logic [VW-1:0] min_top_r, min_top_nxt;
  logic [VW-1:0] max_top_r, max_top_nxt;

  // pop in flight
  logic [VW-1:0] popped_r, popped_nxt;
  logic          pop_min_r, pop_min_nxt;
  logic          pop_max_r, pop_max_nxt;

  // result register
  logic [OUT_VALUE_W-1:0] o_popped_r, o_popped_nxt;
  logic                   o_was_min_r, o_was_min_nxt;
  logic                   o_was_max_r, o_was_max_nxt;
  logic [OUT_VALUE_W-1:0] o_min_r, o_min_nxt;
  logic [OUT_VALUE_W-1:0] o_max_r, o_max_nxt;
  logic [FILL_W-1:0]      o_fill_r, o_fill_nxt;
  logic                   o_empty_r, o_empty_nxt;
  fault_t                 o_fault_r, o_fault_nxt;

  // ram ports
  logic          val_we, min_we, max_we, rd_en;
  logic [AW-1:0] val_wa, min_wa, max_wa, val_ra, min_ra, max_ra;
  logic [VW-1:0] val_rd, min_rd, max_rd;

  logic          accept, out_free, full;
  logic          min_go, max_go, hit_min, hit_max;
  logic [VW-1:0] push_v, new_min, new_max;
  logic [CW-1:0] vc_rd, mc_rd, xc_rd;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // low VALUE_WIDTH bits, sign extended when the store is wider
  assign push_v = VW'(in_value);
  assign full   = (vc_r == CW'(STACK_DEPTH));
  assign min_go = (mc_r == '0) || ($signed(push_v) <= $signed(min_top_r));
  assign max_go = (xc_r == '0) || ($signed(max_top_r) <= $signed(push_v));
  assign hit_min = (mc_r != '0) && (min_top_r == val_top_r);
  assign hit_max = (xc_r != '0) && (max_top_r == val_top_r);

  // entries just below the tops become the new tops after a pop
  assign vc_rd  = vc_r - CW'(2);
  assign mc_rd  = mc_r - CW'(2);
  assign xc_rd  = xc_r - CW'(2);
  assign val_ra = vc_rd[AW-1:0];
  assign min_ra = mc_rd[AW-1:0];
  assign max_ra = xc_rd[AW-1:0];

  // a push writes the new entry at the current count of each stack
  assign val_wa = vc_r[AW-1:0];
  assign min_wa = mc_r[AW-1:0];
  assign max_wa = xc_r[AW-1:0];
  assign val_we = accept && (in_mode == MODE_PUSH) && !full;
  assign min_we = val_we && min_go;
  assign max_we = val_we && max_go;
  assign rd_en  = accept && (in_mode == MODE_POP) && (vc_r != '0);

  // tops as seen when the pop result is formed
  assign new_min = pop_min_r ? min_rd : min_top_r;
  assign new_max = pop_max_r ? max_rd : max_top_r;

  always_comb begin
    state_nxt     = state_r;
    vc_nxt        = vc_r;
    mc_nxt        = mc_r;
    xc_nxt        = xc_r;
    val_top_nxt   = val_top_r;
    min_top_nxt   = min_top_r;
    max_top_nxt   = max_top_r;
    popped_nxt    = popped_r;
    pop_min_nxt   = pop_min_r;
    pop_max_nxt   = pop_max_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_popped_nxt  = o_popped_r;
    o_was_min_nxt = o_was_min_r;
    o_was_max_nxt = o_was_max_r;
    o_min_nxt     = o_min_r;
    o_max_nxt     = o_max_r;
    o_fill_nxt    = o_fill_r;
    o_empty_nxt   = o_empty_r;
    o_fault_nxt   = o_fault_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // defaults for a result that leaves the state as it is
          o_popped_nxt  = '0;
          o_was_min_nxt = 1'b0;
          o_was_max_nxt = 1'b0;
          o_min_nxt     = (vc_r != '0 && mc_r != '0) ? OUT_VALUE_W'($signed(min_top_r)) : '0;
          o_max_nxt     = (vc_r != '0 && xc_r != '0) ? OUT_VALUE_W'($signed(max_top_r)) : '0;
          o_fill_nxt    = FILL_W'(vc_r);
          o_empty_nxt   = (vc_r == '0);
          if (in_mode == MODE_PUSH) begin
            out_valid_nxt = 1'b1;
            if (full) begin
              o_fault_nxt = FAULT_FULL;
            end else begin
              o_fault_nxt = FAULT_NONE;
              vc_nxt      = vc_r + CW'(1);
              val_top_nxt = push_v;
              o_fill_nxt  = FILL_W'(vc_r + CW'(1));
              o_empty_nxt = 1'b0;
              if (min_go) begin
                mc_nxt      = mc_r + CW'(1);
                min_top_nxt = push_v;
                o_min_nxt   = OUT_VALUE_W'($signed(push_v));
              end
              if (max_go) begin
                xc_nxt      = xc_r + CW'(1);
                max_top_nxt = push_v;
                o_max_nxt   = OUT_VALUE_W'($signed(push_v));
              end
            end
          end else if (vc_r == '0) begin
            out_valid_nxt = 1'b1;
            o_fault_nxt   = FAULT_EMPTY;
          end else begin
            // pop: counts move now, tops reload from the rams in the reload state
            vc_nxt      = vc_r - CW'(1);
            mc_nxt      = hit_min ? mc_r - CW'(1) : mc_r;
            xc_nxt      = hit_max ? xc_r - CW'(1) : xc_r;
            popped_nxt  = val_top_r;
            pop_min_nxt = hit_min;
            pop_max_nxt = hit_max;
            state_nxt   = ST_RELOAD;
          end
        end
      end
      ST_RELOAD: begin
        if (out_free) begin
          val_top_nxt   = val_rd;
          min_top_nxt   = new_min;
          max_top_nxt   = new_max;
          out_valid_nxt = 1'b1;
          o_popped_nxt  = OUT_VALUE_W'($signed(popped_r));
          o_was_min_nxt = pop_min_r;
          o_was_max_nxt = pop_max_r;
          o_min_nxt     = (vc_r != '0 && mc_r != '0) ? OUT_VALUE_W'($signed(new_min)) : '0;
          o_max_nxt     = (vc_r != '0 && xc_r != '0) ? OUT_VALUE_W'($signed(new_max)) : '0;
          o_fill_nxt    = FILL_W'(vc_r);
          o_empty_nxt   = (vc_r == '0);
          o_fault_nxt   = FAULT_NONE;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vc_r        <= '0;
      mc_r        <= '0;
      xc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      mc_r        <= mc_nxt;
      xc_r        <= xc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    val_top_r   <= val_top_nxt;
    min_top_r   <= min_top_nxt;
    max_top_r   <= max_top_nxt;
    popped_r    <= popped_nxt;
    pop_min_r   <= pop_min_nxt;
    pop_max_r   <= pop_max_nxt;
    o_popped_r  <= o_popped_nxt;
    o_was_min_r <= o_was_min_nxt;
    o_was_max_r <= o_was_max_nxt;
    o_min_r     <= o_min_nxt;
    o_max_r     <= o_max_nxt;
    o_fill_r    <= o_fill_nxt;
    o_empty_r   <= o_empty_nxt;
    o_fault_r   <= o_fault_nxt;
  end

  // value, min and max stacks
  mms_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_wa),
    .wr_data (push_v),
    .rd_en   (rd_en),
    .rd_addr (val_ra),
    .rd_data (val_rd)
  );

  mms_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_min_ram (
    .clk     (clk),
    .wr_en   (min_we),
    .wr_addr (min_wa),
    .wr_data (push_v),
    .rd_en   (rd_en),
    .rd_addr (min_ra),
    .rd_data (min_rd)
  );

  mms_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_max_ram (
    .clk     (clk),
    .wr_en   (max_we),
    .wr_addr (max_wa),
    .wr_data (push_v),
    .rd_en   (rd_en),
    .rd_addr (max_ra),
    .rd_data (max_rd)
  );

  assign out_valid          = out_valid_r;
  assign out_popped_value   = o_popped_r;
  assign out_popped_was_min = o_was_min_r;
  assign out_popped_was_max = o_was_max_r;
  assign out_current_min    = o_min_r;
  assign out_current_max    = o_max_r;
  assign out_fill_level     = o_fill_r;
  assign out_is_empty       = o_empty_r;
  assign out_fault          = o_fault_r;

  // auxiliary stacks never outgrow the value stack
  `MMS_ASSERT_IMP(a_aux_le_val, clk, rst_n, 1'b1, (mc_r <= vc_r) && (xc_r <= vc_r))
  // a non-empty stack always has a min and a max entry
  `MMS_ASSERT_IMP(a_aux_nonempty, clk, rst_n, vc_r != '0, (mc_r != '0) && (xc_r != '0))
  // a pop that removes a value goes through the reload cycle
  `MMS_ASSERT_NXT(a_pop_reload, clk, rst_n,
    accept && (in_mode == MODE_POP) && (vc_r != '0), state_r == ST_RELOAD)

endmodule
